// ===== src/wf_pkg.sv =====
// wf_pkg: shared types and constants for the 3x3 window pixel filter
// no dependencies; imported by every module of the block except wf_ram

package wf_pkg;

    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int WIN_N      = 9;
    localparam int COL_OUT_W  = 10;
    localparam int ROW_W      = 12;
    localparam int MODE_W     = 3;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int MIN_DIM    = 3;
    localparam int HEIGHT_MAX = 4096;

    localparam int EDGE_SUM_W = CH_W + 2;
    localparam int MEAN_SUM_W = CH_W + 4;
    localparam int RECIP_W    = 13;
    localparam int MEAN_SHIFT = 16;
    localparam logic [RECIP_W-1:0] MEAN_RECIP = 13'd7282;

    localparam logic [MODE_W-1:0] MODE_EDGE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MAX    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MIN    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MEDIAN = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MEAN   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [MODE_W-1:0]  MODE_RESET   = MODE_EDGE;
    localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 13'd768;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pixel_t;

    // upper and middle line entries kept side by side in one word
    typedef struct packed {
        pixel_t upper;
        pixel_t middle;
    } line_pair_t;

endpackage

// ===== src/wf_ram.sv =====
// wf_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies

module wf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/wf_position.sv =====
// wf_position: raster column and row counters with frame restart and wrap
// depends on wf_pkg

module wf_position
    import wf_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic                         frame_start,
    input  logic [IMG_W_W-1:0]           image_width,
    input  logic [IMG_H_W-1:0]           image_height,
    output logic [$clog2(MAX_WIDTH)-1:0] col,
    output logic [ROW_W-1:0]             row
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = ((WW > IMG_W_W) ? WW : IMG_W_W) + 1;
    localparam int HW   = IMG_H_W + 1;

    logic [CW-1:0]    col_cnt_reg;
    logic [CW-1:0]    col_cnt_next;
    logic [ROW_W-1:0] row_cnt_reg;
    logic [ROW_W-1:0] row_cnt_next;
    logic [CMPW-1:0]  width_ext;
    logic [CMPW-1:0]  width_eff;
    logic [CMPW-1:0]  col_inc;
    logic [HW-1:0]    height_ext;
    logic [HW-1:0]    height_eff;
    logic [HW-1:0]    row_inc;

    assign col = frame_start ? '0 : col_cnt_reg;
    assign row = frame_start ? '0 : row_cnt_reg;

    always_comb
    begin
        width_ext  = CMPW'(image_width);
        height_ext = HW'(image_height);
        if (width_ext < CMPW'(MIN_DIM))
        begin
            width_eff = CMPW'(MIN_DIM);
        end
        else if (width_ext > CMPW'(MAX_WIDTH))
        begin
            width_eff = CMPW'(MAX_WIDTH);
        end
        else
        begin
            width_eff = width_ext;
        end
        if (height_ext < HW'(MIN_DIM))
        begin
            height_eff = HW'(MIN_DIM);
        end
        else if (height_ext > HW'(HEIGHT_MAX))
        begin
            height_eff = HW'(HEIGHT_MAX);
        end
        else
        begin
            height_eff = height_ext;
        end
        col_inc = CMPW'(col) + CMPW'(1);
        row_inc = HW'(row) + HW'(1);
    end

    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (advance)
        begin
            if (col_inc >= width_eff)
            begin
                col_cnt_next = '0;
                row_cnt_next = (row_inc >= height_eff) ? '0 : row_inc[ROW_W-1:0];
            end
            else
            begin
                col_cnt_next = col_inc[CW-1:0];
                row_cnt_next = row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

endmodule

// ===== src/wf_filter.sv =====
// wf_filter: one colour channel of the 3x3 filter (edge, max, min, median, mean)
// depends on wf_pkg

module wf_filter
    import wf_pkg::*;
(
    input  logic [MODE_W-1:0] mode,
    input  logic [CH_W-1:0]   win [WIN_N],
    output logic [CH_W-1:0]   result
);

    function automatic logic [CH_W-1:0] min8(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [CH_W-1:0] max8(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    logic [EDGE_SUM_W-1:0]              right_sum;
    logic [EDGE_SUM_W-1:0]              left_sum;
    logic signed [EDGE_SUM_W:0]         edge_diff;
    logic [CH_W-1:0]                    edge_val;
    logic [CH_W-1:0]                    max_val;
    logic [CH_W-1:0]                    min_val;
    logic [CH_W-1:0]                    med_val;
    logic [MEAN_SUM_W-1:0]              mean_sum;
    logic [MEAN_SUM_W+RECIP_W-1:0]      mean_prod;
    logic [CH_W-1:0]                    mean_val;
    logic [CH_W-1:0]                    m [WIN_N];
    logic [CH_W-1:0]                    t;

    always_comb
    begin
        right_sum = EDGE_SUM_W'(win[2]) + EDGE_SUM_W'(win[5]) + EDGE_SUM_W'(win[8]);
        left_sum  = EDGE_SUM_W'(win[0]) + EDGE_SUM_W'(win[3]) + EDGE_SUM_W'(win[6]);
        edge_diff = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
        if (edge_diff < 0)
        begin
            edge_val = '0;
        end
        else if (edge_diff > $signed((EDGE_SUM_W+1)'(255)))
        begin
            edge_val = '1;
        end
        else
        begin
            edge_val = edge_diff[CH_W-1:0];
        end
    end

    always_comb
    begin
        max_val  = '0;
        min_val  = '1;
        mean_sum = '0;
        for (int i = 0; i < WIN_N; i++)
        begin
            max_val  = max8(max_val, win[i]);
            min_val  = min8(min_val, win[i]);
            mean_sum = mean_sum + MEAN_SUM_W'(win[i]);
        end
        // divide by nine through the reciprocal, exact for sums up to 9 * 255
        mean_prod = (MEAN_SUM_W+RECIP_W)'(mean_sum) * (MEAN_SUM_W+RECIP_W)'(MEAN_RECIP);
        mean_val  = mean_prod[MEAN_SHIFT +: CH_W];
    end

    // nineteen compare-exchange median network
    always_comb
    begin
        for (int i = 0; i < WIN_N; i++)
        begin
            m[i] = win[i];
        end
        t = m[1]; m[1] = min8(t, m[2]); m[2] = max8(t, m[2]);
        t = m[4]; m[4] = min8(t, m[5]); m[5] = max8(t, m[5]);
        t = m[7]; m[7] = min8(t, m[8]); m[8] = max8(t, m[8]);
        t = m[0]; m[0] = min8(t, m[1]); m[1] = max8(t, m[1]);
        t = m[3]; m[3] = min8(t, m[4]); m[4] = max8(t, m[4]);
        t = m[6]; m[6] = min8(t, m[7]); m[7] = max8(t, m[7]);
        t = m[1]; m[1] = min8(t, m[2]); m[2] = max8(t, m[2]);
        t = m[4]; m[4] = min8(t, m[5]); m[5] = max8(t, m[5]);
        t = m[7]; m[7] = min8(t, m[8]); m[8] = max8(t, m[8]);
        t = m[0]; m[0] = min8(t, m[3]); m[3] = max8(t, m[3]);
        t = m[5]; m[5] = min8(t, m[8]); m[8] = max8(t, m[8]);
        t = m[4]; m[4] = min8(t, m[7]); m[7] = max8(t, m[7]);
        t = m[3]; m[3] = min8(t, m[6]); m[6] = max8(t, m[6]);
        t = m[1]; m[1] = min8(t, m[4]); m[4] = max8(t, m[4]);
        t = m[2]; m[2] = min8(t, m[5]); m[5] = max8(t, m[5]);
        t = m[4]; m[4] = min8(t, m[7]); m[7] = max8(t, m[7]);
        t = m[4]; m[4] = min8(t, m[2]); m[2] = max8(t, m[2]);
        t = m[6]; m[6] = min8(t, m[4]); m[4] = max8(t, m[4]);
        t = m[4]; m[4] = min8(t, m[2]); m[2] = max8(t, m[2]);
        med_val = m[4];
    end

    always_comb
    begin
        case (mode)
            MODE_MAX:    result = max_val;
            MODE_MIN:    result = min_val;
            MODE_MEDIAN: result = med_val;
            MODE_MEAN:   result = mean_val;
            default:     result = edge_val;
        endcase
    end

endmodule

// ===== src/window_3x3_pixel_filter.sv =====
// window_3x3_pixel_filter: top level, line stores, 3x3 window and output register
// depends on wf_pkg, wf_ram, wf_position, wf_filter
//
// usage
// - pixels arrive in raster order on the input channel (in_valid / in_stall);
//   a transaction happens at a clock edge with in_valid high and in_stall low
// - frame_start marks the first pixel of a frame and restarts column and row
// - each pixel whose window covers an interior position gives one filtered
//   pixel on the output channel (out_valid / out_stall) with the centre
//   column and row; border pixels give no output transaction
// - throughput is one pixel per clock while out_stall is low; the line stores are one ram of
//   MAX_WIDTH words with one read and one write port per cycle
// - a result passes the s1 registers, the window registers and the output register
// - while out_stall is high the output holds and the pipeline fills; in_stall
//   rises once the input stage cannot move on
// - registers are written through cfg_valid / cfg_ready / cfg_index / cfg_data;
//   the user writes them only while the block is idle, the block does not enforce it; cfg_ready is always high
// - reset clears the counters, the window and the pipeline; line store words
//   hold nothing meaningful until written by the first two lines of a frame

module window_3x3_pixel_filter
    import wf_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [CH_W-1:0]       red_in,
    input  logic [CH_W-1:0]       green_in,
    input  logic [CH_W-1:0]       blue_in,
    input  logic                  frame_start,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [CH_W-1:0]       red_out,
    output logic [CH_W-1:0]       green_out,
    output logic [CH_W-1:0]       blue_out,
    output logic [COL_OUT_W-1:0]  center_column,
    output logic [ROW_W-1:0]      center_row
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [MODE_W-1:0]    filter_mode_reg;
    logic [IMG_W_W-1:0]   image_width_reg;
    logic [IMG_H_W-1:0]   image_height_reg;

    logic                 in_accept;
    logic                 s1_adv;
    logic                 s2_adv;
    logic [CW-1:0]        pos_col;
    logic [ROW_W-1:0]     pos_row;

    logic                 s1_valid_reg;
    pixel_t               s1_pix_reg;
    logic [CW-1:0]        s1_col_reg;
    logic [ROW_W-1:0]     s1_row_reg;
    logic                 s1_fwd_reg;
    line_pair_t           s1_fwd_data_reg;
    line_pair_t           ram_rdata;
    line_pair_t           s1_lines;
    line_pair_t           ram_wdata;
    logic                 s1_emit;

    pixel_t               win_reg [WIN_N];
    logic                 s2_pending_reg;
    logic [COL_OUT_W-1:0] s2_col_reg;
    logic [ROW_W-1:0]     s2_row_reg;

    logic [CH_W-1:0]      win_red   [WIN_N];
    logic [CH_W-1:0]      win_green [WIN_N];
    logic [CH_W-1:0]      win_blue  [WIN_N];
    logic [CH_W-1:0]      filt_red;
    logic [CH_W-1:0]      filt_green;
    logic [CH_W-1:0]      filt_blue;

    logic                 out_valid_reg;
    logic [CH_W-1:0]      red_out_reg;
    logic [CH_W-1:0]      green_out_reg;
    logic [CH_W-1:0]      blue_out_reg;
    logic [COL_OUT_W-1:0] col_out_reg;
    logic [ROW_W-1:0]     row_out_reg;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_mode_reg  <= MODE_RESET;
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MODE:   filter_mode_reg  <= cfg_data[MODE_W-1:0];
                CFG_WIDTH:  image_width_reg  <= cfg_data[IMG_W_W-1:0];
                CFG_HEIGHT: image_height_reg <= cfg_data[IMG_H_W-1:0];
                default:    ;
            endcase
        end
    end

    // pipeline flow control
    assign s2_adv    = s2_pending_reg && (!out_valid_reg || !out_stall);
    assign s1_adv    = s1_valid_reg && (!s2_pending_reg || s2_adv);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;

    wf_position #(
        .MAX_WIDTH    (MAX_WIDTH)
    ) u_position (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (in_accept),
        .frame_start  (frame_start),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .col          (pos_col),
        .row          (pos_row)
    );

    // the previous pixel writes its column at the edge that reads it here, so bypass it
    assign s1_lines  = s1_fwd_reg ? s1_fwd_data_reg : ram_rdata;
    assign ram_wdata = '{upper: s1_lines.middle, middle: s1_pix_reg};
    assign s1_emit   = (s1_col_reg >= CW'(2)) && (s1_row_reg >= ROW_W'(2));

    wf_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata (ram_wdata),
        .re    (in_accept),
        .raddr (pos_col),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pix_reg      <= '{red: red_in, green: green_in, blue: blue_in};
            s1_col_reg      <= pos_col;
            s1_row_reg      <= pos_row;
            s1_fwd_reg      <= s1_valid_reg && (s1_col_reg == pos_col);
            s1_fwd_data_reg <= ram_wdata;
        end
    end

    // window shift and pending result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_N; i++)
            begin
                win_reg[i] <= '0;
            end
            s2_pending_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r*3]   <= win_reg[r*3+1];
                win_reg[r*3+1] <= win_reg[r*3+2];
            end
            win_reg[2]     <= s1_lines.upper;
            win_reg[5]     <= s1_lines.middle;
            win_reg[8]     <= s1_pix_reg;
            s2_pending_reg <= s1_emit;
        end
        else if (s2_adv)
        begin
            s2_pending_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_col_reg <= COL_OUT_W'(s1_col_reg - CW'(1));
            s2_row_reg <= s1_row_reg - ROW_W'(1);
        end
    end

    always_comb
    begin
        for (int i = 0; i < WIN_N; i++)
        begin
            win_red[i]   = win_reg[i].red;
            win_green[i] = win_reg[i].green;
            win_blue[i]  = win_reg[i].blue;
        end
    end

    wf_filter u_filter_red (
        .mode   (filter_mode_reg),
        .win    (win_red),
        .result (filt_red)
    );

    wf_filter u_filter_green (
        .mode   (filter_mode_reg),
        .win    (win_green),
        .result (filt_green)
    );

    wf_filter u_filter_blue (
        .mode   (filter_mode_reg),
        .win    (win_blue),
        .result (filt_blue)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            red_out_reg   <= filt_red;
            green_out_reg <= filt_green;
            blue_out_reg  <= filt_blue;
            col_out_reg   <= s2_col_reg;
            row_out_reg   <= s2_row_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign red_out       = red_out_reg;
    assign green_out     = green_out_reg;
    assign blue_out      = blue_out_reg;
    assign center_column = col_out_reg;
    assign center_row    = row_out_reg;

endmodule
